@@ sv/sha1h_pkg.sv @@
// ---------------------------------------------------------------------------
// sha1h_pkg: shared types and constants of the SHA-1 byte stream hasher
// Word type, chaining initial values, round constants and padding byte.
// ---------------------------------------------------------------------------
package sha1h_pkg;

   typedef logic [31:0] word_type;
   typedef logic [7:0]  byte_type;

   localparam word_type H0_INIT = 32'h67452301;
   localparam word_type H1_INIT = 32'hEFCDAB89;
   localparam word_type H2_INIT = 32'h98BADCFE;
   localparam word_type H3_INIT = 32'h10325476;
   localparam word_type H4_INIT = 32'hC3D2E1F0;

   localparam word_type K_ROUND0 = 32'h5A827999;
   localparam word_type K_ROUND1 = 32'h6ED9EBA1;
   localparam word_type K_ROUND2 = 32'h8F1BBCDC;
   localparam word_type K_ROUND3 = 32'hCA62C1D6;

   localparam byte_type PAD_BYTE = 8'h80;

   localparam logic REQ_DATA   = 1'b0;
   localparam logic REQ_FINISH = 1'b1;

   function automatic word_type rotl1(input word_type x);
      rotl1 = {x[30:0], x[31]};
   endfunction

   function automatic word_type rotl5(input word_type x);
      rotl5 = {x[26:0], x[31:27]};
   endfunction

   function automatic word_type rotl30(input word_type x);
      rotl30 = {x[1:0], x[31:2]};
   endfunction

endpackage

@@ sv/sha1h_if.sv @@
// ---------------------------------------------------------------------------
// sha1h_req_if / sha1h_rsp_if: valid/ready channels of the SHA-1 hasher
// Request carries one byte or a finish marker; response carries the digest.
// ---------------------------------------------------------------------------
interface sha1h_req_if;
   logic valid;
   logic ready;
   logic req_type;
   sha1h_pkg::byte_type data_byte;

   modport source (output valid, output req_type, output data_byte, input ready);
   modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface sha1h_rsp_if;
   logic valid;
   logic ready;
   sha1h_pkg::word_type digest_a;
   sha1h_pkg::word_type digest_b;
   sha1h_pkg::word_type digest_c;
   sha1h_pkg::word_type digest_d;
   sha1h_pkg::word_type digest_e;

   modport source (output valid, output digest_a, output digest_b, output digest_c,
                   output digest_d, output digest_e, input ready);
   modport sink   (input valid, input digest_a, input digest_b, input digest_c,
                   input digest_d, input digest_e, output ready);
endinterface

@@ sv/sha1_byte_stream_hasher.sv @@
// ---------------------------------------------------------------------------
// sha1_byte_stream_hasher: streaming SHA-1 over a byte stream
// Buffers message bytes in a 16 x 32 block memory, compresses each full
// block with one round per cycle and pads and emits the digest on finish.
// ---------------------------------------------------------------------------
//  channel   | dir | payload                         | moves
//  ----------+-----+---------------------------------+-----------------------
//  req_ch    | in  | req_type, data_byte             | one byte or finish
//  rsp_ch    | out | digest_a .. digest_e            | one digest per finish
//
//  A data item is written while idle; the item that fills the block starts a
//  compression (one memory read lead-in, 80 rounds, one chaining add), and no
//  item is taken until it ends. A finish item writes the padding bytes (9 to
//  72) one at a time, compresses one or two blocks and hands over the digest.
//  Reset is synchronous and restores the initial chaining values; the block
//  memory needs no clearing. A stalled response holds in its output register
//  while further data items are taken; a second digest waits for the slot.
// ---------------------------------------------------------------------------
module sha1_byte_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   sha1h_req_if.sink   req_ch,
   sha1h_rsp_if.source rsp_ch
);

   localparam int ROUNDS = 80;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PAD   = 3'd1;
   localparam logic [2:0] ST_LOAD  = 3'd2;
   localparam logic [2:0] ST_ROUND = 3'd3;
   localparam logic [2:0] ST_ADD   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
   localparam logic [5:0] FILL_LAST  = 6'd63;
   localparam logic [5:0] FILL_LEN   = 6'd56;

   // control state
   logic [2:0]  state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic        padding_ff, padding_in;   // finish in progress
   logic        first_ff, first_in;       // next pad byte is the marker byte
   logic        len_ff, len_in;           // writing the length field
   logic [6:0]  round_ff, round_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // chaining words and working variables
   sha1h_pkg::word_type h_ff [5];
   sha1h_pkg::word_type h_in [5];
   sha1h_pkg::word_type a_ff, b_ff, c_ff, d_ff, e_ff;
   sha1h_pkg::word_type a_in, b_in, c_in, d_in, e_in;

   // message schedule window, index 15 holds the newest word
   sha1h_pkg::word_type sched_ff [16];

   // response payload
   sha1h_pkg::word_type dig_a_ff, dig_b_ff, dig_c_ff, dig_d_ff, dig_e_ff;
   logic                load_out;

   // block memory, big-endian bytes within each word
   sha1h_pkg::word_type blk_mem [16];
   sha1h_pkg::word_type rd_data_ff;
   logic [3:0]          rd_addr;
   logic                wr_en;
   sha1h_pkg::byte_type wr_byte;
   logic [1:0]          wr_lane;

   // round datapath
   sha1h_pkg::word_type w_cur, f_val, k_val, t_val;

   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.digest_a = dig_a_ff;
   assign rsp_ch.digest_b = dig_b_ff;
   assign rsp_ch.digest_c = dig_c_ff;
   assign rsp_ch.digest_d = dig_d_ff;
   assign rsp_ch.digest_e = dig_e_ff;

   assign wr_lane = ~fill_ff[1:0];
   assign rd_addr = (state_ff == ST_LOAD) ? 4'd0 : 4'(round_ff[3:0] + 4'd1);

   // read one word a cycle, write one byte lane a cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= blk_mem[rd_addr];
      if (wr_en) begin
         blk_mem[fill_ff[5:2]][{wr_lane, 3'b000} +: 8] <= wr_byte;
      end
   end

   // round function: memory words for the first sixteen rounds, then expand
   always_comb begin
      if (round_ff < 7'd16) begin
         w_cur = rd_data_ff;
      end else begin
         w_cur = sha1h_pkg::rotl1(sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0]);
      end
      if (round_ff < 7'd20) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = sha1h_pkg::K_ROUND0;
      end else if (round_ff < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = sha1h_pkg::K_ROUND1;
      end else if (round_ff < 7'd60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = sha1h_pkg::K_ROUND2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = sha1h_pkg::K_ROUND3;
      end
      t_val = sha1h_pkg::rotl5(a_ff) + f_val + e_ff + k_val + w_cur;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      bits_in      = bits_ff;
      padding_in   = padding_ff;
      first_in     = first_ff;
      len_in       = len_ff;
      round_in     = round_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      load_out     = 1'b0;
      wr_en        = 1'b0;
      wr_byte      = '0;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      for (int i = 0; i < 5; i++) begin
         h_in[i] = h_ff[i];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.req_type == sha1h_pkg::REQ_DATA) begin
                  // append the byte, compress once the block is full
                  wr_en   = 1'b1;
                  wr_byte = req_ch.data_byte;
                  fill_in = fill_ff + 6'd1;
                  bits_in = bits_ff + 64'd8;
                  if (fill_ff == FILL_LAST) begin
                     state_in = ST_LOAD;
                  end
               end else begin
                  padding_in = 1'b1;
                  first_in   = 1'b1;
                  state_in   = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // marker byte, then zeros up to the length field, then the length
            wr_en = 1'b1;
            if (first_ff) begin
               wr_byte  = sha1h_pkg::PAD_BYTE;
               first_in = 1'b0;
            end else if (len_ff || fill_ff == FILL_LEN) begin
               wr_byte = bits_ff[{~fill_ff[2:0], 3'b000} +: 8];
               len_in  = 1'b1;
            end else begin
               wr_byte = '0;
            end
            fill_in = fill_ff + 6'd1;
            if (fill_ff == FILL_LAST) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // word 0 is being read; seed the working variables
            round_in = '0;
            a_in = h_ff[0]; b_in = h_ff[1]; c_in = h_ff[2];
            d_in = h_ff[3]; e_in = h_ff[4];
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            a_in = t_val;
            b_in = a_ff;
            c_in = sha1h_pkg::rotl30(b_ff);
            d_in = c_ff;
            e_in = d_ff;
            round_in = round_ff + 7'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            h_in[0] = h_ff[0] + a_ff;
            h_in[1] = h_ff[1] + b_ff;
            h_in[2] = h_ff[2] + c_ff;
            h_in[3] = h_ff[3] + d_ff;
            h_in[4] = h_ff[4] + e_ff;
            if (len_ff) begin
               state_in = ST_DONE;
            end else if (padding_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DONE: begin
            // hand over the digest once the output slot is free, then restart
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
               h_in[0] = sha1h_pkg::H0_INIT;
               h_in[1] = sha1h_pkg::H1_INIT;
               h_in[2] = sha1h_pkg::H2_INIT;
               h_in[3] = sha1h_pkg::H3_INIT;
               h_in[4] = sha1h_pkg::H4_INIT;
               fill_in    = '0;
               bits_in    = '0;
               padding_in = 1'b0;
               first_in   = 1'b0;
               len_in     = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         bits_ff      <= '0;
         padding_ff   <= 1'b0;
         first_ff     <= 1'b0;
         len_ff       <= 1'b0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         h_ff[0]      <= sha1h_pkg::H0_INIT;
         h_ff[1]      <= sha1h_pkg::H1_INIT;
         h_ff[2]      <= sha1h_pkg::H2_INIT;
         h_ff[3]      <= sha1h_pkg::H3_INIT;
         h_ff[4]      <= sha1h_pkg::H4_INIT;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         bits_ff      <= bits_in;
         padding_ff   <= padding_in;
         first_ff     <= first_in;
         len_ff       <= len_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 5; i++) begin
            h_ff[i] <= h_in[i];
         end
      end
   end

   // working variables, schedule window and response payload
   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
      if (state_ff == ST_ROUND) begin
         for (int i = 0; i < 15; i++) begin
            sched_ff[i] <= sched_ff[i + 1];
         end
         sched_ff[15] <= w_cur;
      end
      if (load_out) begin
         dig_a_ff <= h_ff[0];
         dig_b_ff <= h_ff[1];
         dig_c_ff <= h_ff[2];
         dig_d_ff <= h_ff[3];
         dig_e_ff <= h_ff[4];
      end
   end

endmodule

@@ verif/sha1_byte_stream_hasher_test.sv @@
// ---------------------------------------------------------------------------
// sha1_byte_stream_hasher_test: self-checking bench for the SHA-1 hasher
// Streams messages of assorted lengths one byte per item. A behavioural SHA-1
// works out each digest as its finish item is accepted, and every digest that
// comes back is compared word by word against the oldest one still awaited.
// ---------------------------------------------------------------------------
module sha1_byte_stream_hasher_test;

   // Stimulus sizing: stop adding random messages once both targets are met.
   localparam int RANDOM_ITEMS  = 1100;
   localparam int MIN_MESSAGES  = 20;
   // Longest correct silence is a two-block finish (up to 72 pad bytes plus
   // two compressions) or a drain pause; allow many times that.
   localparam int STALL_LIMIT   = 3000;
   // Let any trailing compression run out before the verdict.
   localparam int SETTLE_CYCLES = 200;
   // Both sides run without gaps inside this window of cycles.
   localparam int CALM_START    = 2000;
   localparam int CALM_END      = 4000;
   // Message lengths around the padding and block boundaries.
   localparam int BOUNDARY_LEN [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

   typedef struct {
      logic                kind;
      sha1h_pkg::byte_type data;
      bit                  wait_drain;   // hold this item until no digest is awaited
   } stream_item_type;

   typedef struct {
      sha1h_pkg::word_type a;
      sha1h_pkg::word_type b;
      sha1h_pkg::word_type c;
      sha1h_pkg::word_type d;
      sha1h_pkg::word_type e;
   } digest_words_type;

   logic clock;
   logic reset;

   sha1h_req_if req_ch ();
   sha1h_rsp_if rsp_ch ();

   sha1_byte_stream_hasher u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Items waiting to be offered, and digests the hasher still owes us.
   stream_item_type  pending_items [$];
   digest_words_type expected_digests [$];
   stream_item_type  next_item;

   // Running hash of the message in progress.
   sha1h_pkg::word_type chain_words [5];
   sha1h_pkg::byte_type block_bytes [64];
   int                  block_count;
   logic [63:0]         bit_length;

   int            failures     = 0;
   int            queued_items = 0;
   int            cycle_count  = 0;
   int            quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // SHA-1 prediction
   // -------------------------------------------------------------------------
   function automatic sha1h_pkg::word_type rotate_left(sha1h_pkg::word_type x,
                                                       int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // Restore the chaining values and an empty block, as after reset.
   task automatic clear_hash_state();
      chain_words[0] = sha1h_pkg::H0_INIT;
      chain_words[1] = sha1h_pkg::H1_INIT;
      chain_words[2] = sha1h_pkg::H2_INIT;
      chain_words[3] = sha1h_pkg::H3_INIT;
      chain_words[4] = sha1h_pkg::H4_INIT;
      block_count    = 0;
      bit_length     = '0;
   endtask

   // Fold the full 64-byte block into the chaining words: 80 rounds.
   task automatic compress_block();
      sha1h_pkg::word_type sched [80];
      sha1h_pkg::word_type a, b, c, d, e, f, k, t;
      int i;
      for (i = 0; i < 16; i++)
         sched[i] = {block_bytes[4*i], block_bytes[4*i+1],
                     block_bytes[4*i+2], block_bytes[4*i+3]};
      for (i = 16; i < 80; i++)
         sched[i] = rotate_left(sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16], 1);
      a = chain_words[0];
      b = chain_words[1];
      c = chain_words[2];
      d = chain_words[3];
      e = chain_words[4];
      for (i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = sha1h_pkg::K_ROUND0;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = sha1h_pkg::K_ROUND1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = sha1h_pkg::K_ROUND2;
         end else begin
            f = b ^ c ^ d;
            k = sha1h_pkg::K_ROUND3;
         end
         t = rotate_left(a, 5) + f + e + k + sched[i];
         e = d;
         d = c;
         c = rotate_left(b, 30);
         b = a;
         a = t;
      end
      chain_words[0] += a;
      chain_words[1] += b;
      chain_words[2] += c;
      chain_words[3] += d;
      chain_words[4] += e;
   endtask

   task automatic absorb_byte(sha1h_pkg::byte_type v);
      block_bytes[block_count] = v;
      block_count++;
      if (block_count == 64) begin
         compress_block();
         block_count = 0;
      end
   endtask

   // Advance the hash by one accepted item; a finish pads, queues the digest
   // and starts a fresh message. The length field uses the wrapped bit count.
   task automatic hash_item(logic kind, sha1h_pkg::byte_type v);
      digest_words_type dig;
      logic [63:0] len;
      int i;
      if (kind == sha1h_pkg::REQ_DATA) begin
         absorb_byte(v);
         bit_length += 64'd8;
      end else begin
         len = bit_length;
         absorb_byte(sha1h_pkg::PAD_BYTE);
         while (block_count != 56)
            absorb_byte(8'h00);
         for (i = 0; i < 8; i++)
            absorb_byte(len[63 - 8*i -: 8]);
         dig.a = chain_words[0];
         dig.b = chain_words[1];
         dig.c = chain_words[2];
         dig.d = chain_words[3];
         dig.e = chain_words[4];
         expected_digests.insert(expected_digests.size(), dig);
         clear_hash_state();
      end
   endtask

   // -------------------------------------------------------------------------
   // Stimulus building
   // -------------------------------------------------------------------------
   task automatic add_byte(sha1h_pkg::byte_type v, bit drain);
      stream_item_type it;
      it.kind       = sha1h_pkg::REQ_DATA;
      it.data       = v;
      it.wait_drain = drain;
      pending_items.insert(pending_items.size(), it);
   endtask

   task automatic add_finish(bit drain);
      stream_item_type it;
      it.kind       = sha1h_pkg::REQ_FINISH;
      it.data       = sha1h_pkg::byte_type'($urandom_range(255));   // ignored by the hasher
      it.wait_drain = drain;
      pending_items.insert(pending_items.size(), it);
   endtask

   // Queue one whole message; the first item carries the drain hold, if any.
   // Some messages are a single repeated byte so that all-zero and all-one
   // blocks get through the rounds too.
   task automatic add_message(int len, bit drain);
      bit                  flat;
      sha1h_pkg::byte_type flat_value;
      int                  i;
      flat       = ($urandom_range(4) == 0);
      flat_value = $urandom_range(1) ? 8'hFF : 8'h00;
      for (i = 0; i < len; i++)
         add_byte(flat ? flat_value : sha1h_pkg::byte_type'($urandom_range(255)),
                  drain && i == 0);
      add_finish(drain && len == 0);
      queued_items += len + 1;
   endtask

   // Random gap for either side, suppressed inside the calm window.
   function automatic bit take_gap();
      if (cycle_count >= CALM_START && cycle_count < CALM_END)
         return 1'b0;
      return $urandom_range(99) < 26;
   endfunction

   // -------------------------------------------------------------------------
   // Driver: offer the oldest pending item, hold it until taken.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         // predict from what the hasher actually took
         if (req_ch.valid)
            hash_item(req_ch.req_type, req_ch.data_byte);
         if (pending_items.size() != 0 && !take_gap() &&
             !(pending_items[0].wait_drain && expected_digests.size() != 0)) begin
            next_item = pending_items.pop_front();
            req_ch.valid     <= 1'b1;
            req_ch.req_type  <= next_item.kind;
            req_ch.data_byte <= next_item.data;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: take each digest and compare it against the oldest expectation.
   // -------------------------------------------------------------------------
   task automatic compare_word(string name, sha1h_pkg::word_type exp_w,
                               sha1h_pkg::word_type act_w);
      if (act_w !== exp_w) begin
         $error("%s mismatch: expected %08h, got %08h", name, exp_w, act_w);
         failures++;
      end
   endtask

   task automatic check_digest();
      digest_words_type dig;
      if (expected_digests.size() == 0) begin
         $error("digest returned with none awaited: %08h %08h %08h %08h %08h",
                rsp_ch.digest_a, rsp_ch.digest_b, rsp_ch.digest_c,
                rsp_ch.digest_d, rsp_ch.digest_e);
         failures++;
      end else begin
         dig = expected_digests.pop_front();
         compare_word("digest_a", dig.a, rsp_ch.digest_a);
         compare_word("digest_b", dig.b, rsp_ch.digest_b);
         compare_word("digest_c", dig.c, rsp_ch.digest_c);
         compare_word("digest_d", dig.d, rsp_ch.digest_d);
         compare_word("digest_e", dig.e, rsp_ch.digest_e);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            check_digest();
         rsp_ch.ready <= !take_gap();
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: end the run if neither channel moves for too long.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Sequence: reset, directed messages, random messages, drain, verdict.
   // -------------------------------------------------------------------------
   initial begin
      int mode;
      int msg_len;
      int messages;

      // hold every input at a known value from time zero
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.req_type  = sha1h_pkg::REQ_DATA;
      req_ch.data_byte = '0;
      rsp_ch.ready     = 1'b0;
      clear_hash_state();

      // Directed: empty message (after a drain), a second finish straight
      // behind it, the classic three-letter message, the extreme byte values
      // and a lone padding-valued byte.
      add_finish(1'b1);
      add_finish(1'b0);
      add_byte(8'h61, 1'b0);
      add_byte(8'h62, 1'b0);
      add_byte(8'h63, 1'b0);
      add_finish(1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_finish(1'b0);
      add_byte(sha1h_pkg::PAD_BYTE, 1'b1);
      add_finish(1'b0);

      // Random: mostly short messages, a share sitting on the padding and
      // block boundaries, the rest spread up to two blocks and a bit.
      messages = 0;
      while (queued_items < RANDOM_ITEMS || messages < MIN_MESSAGES) begin
         mode = $urandom_range(7);
         if (mode < 4)
            msg_len = $urandom_range(20);
         else if (mode < 6)
            msg_len = BOUNDARY_LEN[$urandom_range(8)];
         else
            msg_len = $urandom_range(130);
         add_message(msg_len, $urandom_range(5) == 0);
         messages++;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // wait until every item is taken and every digest is back
      while (pending_items.size() != 0 || req_ch.valid || expected_digests.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/sha1h_pkg.sv
sv/sha1h_if.sv
sv/sha1_byte_stream_hasher.sv
verif/sha1_byte_stream_hasher_test.sv
